FILE: rtl/touch_report_decoder_macros.svh
// Assertion macros for the touch report decoder.
`ifndef TOUCH_REPORT_DECODER_MACROS_SVH
`define TOUCH_REPORT_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define TRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define TRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TRD_ASSERT_NOW(lbl, ante, cons, msg)
`define TRD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/trd_pkg.sv
// Types, constants and defaults shared by the touch report decoder.
package trd_pkg;

  localparam int COORD_BITS       = 12;
  localparam int SCREEN_BITS      = 16;
  localparam int PROD_W           = COORD_BITS + SCREEN_BITS;
  localparam int RADIX_BITS       = 4;
  localparam int DIV_STEPS        = PROD_W / RADIX_BITS;
  localparam int PACKET_BYTES_DEF = 25;
  localparam int FINGER_SLOTS_DEF = 5;
  localparam int SLOT_BASE        = 2;
  localparam int CFG_W            = 16;

  localparam logic [7:0] TYPE_REPORT = 8'h5D;
  localparam logic [7:0] TYPE_NOISE  = 8'h40;
  localparam logic [7:0] VAL_NOISY   = 8'h41;
  localparam logic [7:0] TYPE_CALIB  = 8'h66;
  localparam logic [7:0] TYPE_HELLO  = 8'h55;
  localparam logic [2:0] COUNT_MASK  = 3'h7;
  localparam logic [7:0] LOW_NIB     = 8'h0f;
  localparam logic [7:0] HIGH_NIB    = 8'hf0;

  localparam logic [2:0] EV_POINT    = 3'd0;
  localparam logic [2:0] EV_EMPTY    = 3'd1;
  localparam logic [2:0] EV_NOFINGER = 3'd2;
  localparam logic [2:0] EV_FRAMEEND = 3'd3;
  localparam logic [2:0] EV_NOISE    = 3'd4;
  localparam logic [2:0] EV_CALIB    = 3'd5;
  localparam logic [2:0] EV_HELLO    = 3'd6;

  localparam logic [2:0] CFG_DISP_MAX_X   = 3'd0;
  localparam logic [2:0] CFG_DISP_MAX_Y   = 3'd1;
  localparam logic [2:0] CFG_PANEL_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_PANEL_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_MIRROR_X     = 3'd4;
  localparam logic [2:0] CFG_MIRROR_Y     = 3'd5;
  localparam logic [2:0] CFG_SWAP_AXES    = 3'd6;

  localparam logic [15:0] DISP_MAX_X_RST = 16'd800;
  localparam logic [15:0] DISP_MAX_Y_RST = 16'd480;
  localparam logic [11:0] PANEL_EXT_RST  = 12'd4095;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } trd_in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [2:0]  slot_number;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        noisy;
  } trd_out_t;

  typedef struct packed {
    logic                   start;
    logic [COORD_BITS-1:0]  value;
    logic [SCREEN_BITS-1:0] smax;
    logic [COORD_BITS-1:0]  ext;
  } sc_req_t;

  typedef struct packed {
    logic                   done;
    logic [SCREEN_BITS-1:0] result;
  } sc_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_X,
    ST_WAIT_X,
    ST_START_Y,
    ST_WAIT_Y,
    ST_PUSH
  } trd_state_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV,
    SC_DONE
  } sc_state_t;

endpackage

FILE: rtl/trd_scaler.sv
// Shared multiply and radix-16 restoring divide unit for coordinate scaling.
`include "touch_report_decoder_macros.svh"

module trd_scaler (
  input  logic             clk,
  input  logic             rst,
  input  trd_pkg::sc_req_t req,
  output trd_pkg::sc_rsp_t rsp
);

  localparam int CNT_W = $clog2(trd_pkg::DIV_STEPS);

  trd_pkg::sc_state_t state, state_next;

  logic [CNT_W-1:0]                  cnt;
  logic [trd_pkg::PROD_W-1:0]        num;
  logic [trd_pkg::PROD_W-1:0]        quo;
  logic [trd_pkg::COORD_BITS-1:0]    rem;
  logic [trd_pkg::COORD_BITS-1:0]    value_q;
  logic [trd_pkg::COORD_BITS-1:0]    ext_q;
  logic [trd_pkg::SCREEN_BITS-1:0]   smax_q;

  logic [trd_pkg::PROD_W-1:0]        num_next;
  logic [trd_pkg::PROD_W-1:0]        quo_next;
  logic [trd_pkg::COORD_BITS-1:0]    rem_next;
  logic                              last_step;

  always_comb begin
    logic [trd_pkg::COORD_BITS:0] t;
    num_next = num;
    quo_next = quo;
    rem_next = rem;
    t = '0;
    for (int i = 0; i < trd_pkg::RADIX_BITS; i++) begin
      t = {rem_next, num_next[trd_pkg::PROD_W-1]};
      num_next = {num_next[trd_pkg::PROD_W-2:0], 1'b0};
      if (t >= {1'b0, ext_q}) begin
        t = t - {1'b0, ext_q};
        quo_next = {quo_next[trd_pkg::PROD_W-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[trd_pkg::PROD_W-2:0], 1'b0};
      end
      rem_next = t[trd_pkg::COORD_BITS-1:0];
    end
  end

  assign last_step = (cnt == CNT_W'(trd_pkg::DIV_STEPS - 1));

  always_comb begin
    state_next = state;
    case (state)
      trd_pkg::SC_IDLE: if (req.start) state_next = trd_pkg::SC_MUL;
      trd_pkg::SC_MUL:  state_next = trd_pkg::SC_DIV;
      trd_pkg::SC_DIV:  if (last_step) state_next = trd_pkg::SC_DONE;
      trd_pkg::SC_DONE: state_next = trd_pkg::SC_IDLE;
      default:          state_next = trd_pkg::SC_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state == trd_pkg::SC_DONE);
    if (ext_q == '0) begin
      rsp.result = '0;
    end else if (quo > trd_pkg::PROD_W'(smax_q)) begin
      rsp.result = smax_q;
    end else begin
      rsp.result = quo[trd_pkg::SCREEN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trd_pkg::SC_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == trd_pkg::SC_MUL) begin
        cnt <= '0;
      end else if (state == trd_pkg::SC_DIV) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      trd_pkg::SC_IDLE: begin
        if (req.start) begin
          value_q <= req.value;
          smax_q  <= req.smax;
          ext_q   <= req.ext;
        end
      end
      trd_pkg::SC_MUL: begin
        num <= trd_pkg::PROD_W'(value_q) * trd_pkg::PROD_W'(smax_q);
        quo <= '0;
        rem <= '0;
      end
      trd_pkg::SC_DIV: begin
        num <= num_next;
        quo <= quo_next;
        rem <= rem_next;
      end
      default: begin
      end
    endcase
  end

  `TRD_ASSERT_NOW(a_start_idle, req.start, state == trd_pkg::SC_IDLE, "start while busy")
  `TRD_ASSERT_NOW(a_sat, rsp.done, rsp.result <= smax_q, "result above screen extent")
  `TRD_ASSERT_NOW(a_rem, (state == trd_pkg::SC_DIV) && (ext_q != '0), rem < ext_q, "remainder")
  `TRD_ASSERT_NEXT(a_mul, state == trd_pkg::SC_MUL, (rem == '0) && (cnt == '0), "divide init")

endmodule

FILE: rtl/touch_report_decoder.sv
// Top level of the touch report decoder: packet parser, sequencer, output register.
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    trd_pkg::trd_in_t  (data_byte, packet_start)
// out      output     out_valid / out_ready  trd_pkg::trd_out_t (one event)
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// A byte that gives no event leaves the sequencer in ST_IDLE; a status, slot-empty or
// frame-end event passes through ST_PUSH. A point byte runs the shared scaler for x then
// y, each pass being operand latch, multiply, 7 radix-16 divide steps, result.
// Synchronous reset clears control state, loads configuration defaults; no clearing pass.
// A waiting result does not block bytes that give no event; a new event waits in
// ST_PUSH until the output register is free.

module touch_report_decoder #(
  parameter int PACKET_BYTES = trd_pkg::PACKET_BYTES_DEF,
  parameter int FINGER_SLOTS = trd_pkg::FINGER_SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  trd_pkg::trd_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output trd_pkg::trd_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [trd_pkg::CFG_W-1:0] cfg_data
);

  localparam int POS_W = $clog2(PACKET_BYTES);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(PACKET_BYTES - 1);
  localparam logic [POS_W-1:0] SLOT_LO   = POS_W'(trd_pkg::SLOT_BASE);
  localparam logic [POS_W-1:0] SLOT_END  = POS_W'(trd_pkg::SLOT_BASE + 3 * FINGER_SLOTS);
  localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);

  trd_pkg::trd_state_t state, state_next;

  logic [15:0] disp_max_x, disp_max_y;
  logic [11:0] panel_width, panel_height;
  logic        mirror_x, mirror_y, swap_axes;

  logic [POS_W-1:0] byte_position;
  logic [7:0]       packet_type;
  logic [2:0]       finger_count;
  logic [7:0]       slot_first_byte;
  logic [7:0]       slot_second_byte;

  logic [trd_pkg::COORD_BITS-1:0] x_raw, y_raw;
  logic [15:0]                    scaled_x;
  trd_pkg::trd_out_t              pend;

  trd_pkg::sc_req_t sc_req;
  trd_pkg::sc_rsp_t sc_rsp;

  logic             acc;
  logic             push_load;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] rel;
  logic [8:0]       slot_prod;
  logic [2:0]       slot_idx;
  logic [POS_W-1:0] phase_full;
  logic [1:0]       phase;
  logic             in_slots;
  logic             dec_emit;
  logic             dec_point;
  trd_pkg::trd_out_t dec_ev;
  logic [15:0]      mx, my;

  assign acc       = in_valid && in_ready;
  assign push_load = (state == trd_pkg::ST_PUSH) && (!out_valid || out_ready);

  // slot = rel / 3 via reciprocal, exact for rel below 24
  assign pos_inc    = byte_position + POS_W'(1);
  assign rel        = pos_inc - SLOT_LO;
  assign slot_prod  = 9'(rel) * 9'd11;
  assign slot_idx   = slot_prod[7:5];
  assign phase_full = rel - POS_W'(slot_idx) * POS_W'(3);
  assign phase      = phase_full[1:0];
  assign in_slots   = (pos_inc >= SLOT_LO) && (pos_inc < SLOT_END);

  always_comb begin
    dec_emit  = 1'b0;
    dec_point = 1'b0;
    dec_ev    = '0;
    if (in_data.packet_start) begin
      if (in_data.data_byte == trd_pkg::TYPE_CALIB) begin
        dec_emit = 1'b1;
        dec_ev.event_kind = trd_pkg::EV_CALIB;
      end else if (in_data.data_byte == trd_pkg::TYPE_HELLO) begin
        dec_emit = 1'b1;
        dec_ev.event_kind = trd_pkg::EV_HELLO;
      end
    end else if (byte_position < LAST_POS) begin
      if (packet_type == trd_pkg::TYPE_NOISE) begin
        if (pos_inc == POS_ONE) begin
          dec_emit = 1'b1;
          dec_ev.event_kind = trd_pkg::EV_NOISE;
          dec_ev.noisy = (in_data.data_byte == trd_pkg::VAL_NOISY);
        end
      end else if (packet_type == trd_pkg::TYPE_REPORT) begin
        if (pos_inc == POS_ONE) begin
          if ((in_data.data_byte[2:0] & trd_pkg::COUNT_MASK) == 3'd0) begin
            dec_emit = 1'b1;
            dec_ev.event_kind = trd_pkg::EV_NOFINGER;
          end
        end else if (in_slots && (phase == 2'd2) && (finger_count != 3'd0)) begin
          dec_ev.slot_number = slot_idx;
          if ((slot_first_byte == 8'd0) && (slot_second_byte == 8'd0) &&
              (in_data.data_byte == 8'd0)) begin
            dec_emit = 1'b1;
            dec_ev.event_kind = trd_pkg::EV_EMPTY;
          end else begin
            dec_point = 1'b1;
            dec_ev.event_kind = trd_pkg::EV_POINT;
          end
        end else if (pos_inc == LAST_POS) begin
          dec_emit = 1'b1;
          dec_ev.event_kind = trd_pkg::EV_FRAMEEND;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      trd_pkg::ST_IDLE: begin
        if (acc && dec_point) begin
          state_next = trd_pkg::ST_START_X;
        end else if (acc && dec_emit) begin
          state_next = trd_pkg::ST_PUSH;
        end
      end
      trd_pkg::ST_START_X: state_next = trd_pkg::ST_WAIT_X;
      trd_pkg::ST_WAIT_X:  if (sc_rsp.done) state_next = trd_pkg::ST_START_Y;
      trd_pkg::ST_START_Y: state_next = trd_pkg::ST_WAIT_Y;
      trd_pkg::ST_WAIT_Y:  if (sc_rsp.done) state_next = trd_pkg::ST_PUSH;
      trd_pkg::ST_PUSH:    if (push_load) state_next = trd_pkg::ST_IDLE;
      default:             state_next = trd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == trd_pkg::ST_IDLE);
    sc_req.start = (state == trd_pkg::ST_START_X) || (state == trd_pkg::ST_START_Y);
    if ((state == trd_pkg::ST_START_Y) || (state == trd_pkg::ST_WAIT_Y)) begin
      sc_req.value = y_raw;
      sc_req.smax  = disp_max_y;
      sc_req.ext   = panel_height;
    end else begin
      sc_req.value = x_raw;
      sc_req.smax  = disp_max_x;
      sc_req.ext   = panel_width;
    end
  end

  trd_scaler u_scaler (
    .clk (clk),
    .rst (rst),
    .req (sc_req),
    .rsp (sc_rsp)
  );

  assign mx = mirror_x ? (disp_max_x - scaled_x) : scaled_x;
  assign my = mirror_y ? (disp_max_y - sc_rsp.result) : sc_rsp.result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= trd_pkg::ST_IDLE;
      out_valid    <= 1'b0;
      disp_max_x   <= trd_pkg::DISP_MAX_X_RST;
      disp_max_y   <= trd_pkg::DISP_MAX_Y_RST;
      panel_width  <= trd_pkg::PANEL_EXT_RST;
      panel_height <= trd_pkg::PANEL_EXT_RST;
      mirror_x     <= 1'b0;
      mirror_y     <= 1'b0;
      swap_axes    <= 1'b0;
      byte_position    <= '0;
      packet_type      <= '0;
      finger_count     <= '0;
      slot_first_byte  <= '0;
      slot_second_byte <= '0;
    end else begin
      state <= state_next;
      if (push_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          trd_pkg::CFG_DISP_MAX_X:   disp_max_x   <= cfg_data;
          trd_pkg::CFG_DISP_MAX_Y:   disp_max_y   <= cfg_data;
          trd_pkg::CFG_PANEL_WIDTH:  panel_width  <= cfg_data[11:0];
          trd_pkg::CFG_PANEL_HEIGHT: panel_height <= cfg_data[11:0];
          trd_pkg::CFG_MIRROR_X:     mirror_x     <= cfg_data[0];
          trd_pkg::CFG_MIRROR_Y:     mirror_y     <= cfg_data[0];
          trd_pkg::CFG_SWAP_AXES:    swap_axes    <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (acc) begin
        if (in_data.packet_start) begin
          byte_position <= '0;
          packet_type   <= in_data.data_byte;
          finger_count  <= '0;
        end else if (byte_position < LAST_POS) begin
          byte_position <= pos_inc;
          if (packet_type == trd_pkg::TYPE_REPORT) begin
            if (pos_inc == POS_ONE) begin
              finger_count <= in_data.data_byte[2:0] & trd_pkg::COUNT_MASK;
            end else if (in_slots && (phase == 2'd0)) begin
              slot_first_byte <= in_data.data_byte;
            end else if (in_slots && (phase == 2'd1)) begin
              slot_second_byte <= in_data.data_byte;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (dec_emit || dec_point)) begin
      pend <= dec_ev;
    end
    if (acc && dec_point) begin
      x_raw <= {slot_first_byte[3:0] & trd_pkg::LOW_NIB[3:0], in_data.data_byte};
      y_raw <= {slot_first_byte[7:4] & trd_pkg::HIGH_NIB[7:4], slot_second_byte};
    end
    if ((state == trd_pkg::ST_WAIT_X) && sc_rsp.done) begin
      scaled_x <= sc_rsp.result;
    end
    if ((state == trd_pkg::ST_WAIT_Y) && sc_rsp.done) begin
      pend.pos_x <= swap_axes ? my : mx;
      pend.pos_y <= swap_axes ? mx : my;
    end
    if (push_load) begin
      out_data <= pend;
    end
  end

endmodule

FILE: tb/tb.sv
// Self-checking testbench for touch_report_decoder: packet byte stimulus and an event predictor.
`timescale 1ns / 1ps

module tb;

  localparam int PKT_LEN   = trd_pkg::PACKET_BYTES_DEF;
  localparam int NUM_SLOTS = trd_pkg::FINGER_SLOTS_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  trd_pkg::trd_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  trd_pkg::trd_out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [trd_pkg::CFG_W-1:0] cfg_data = '0;

  touch_report_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of configuration and parser state
  logic [15:0] scr_x, scr_y;
  logic [11:0] pan_w, pan_h;
  logic flip_x, flip_y, swap_xy;
  logic [4:0] byte_idx;
  logic [7:0] pkt_kind;
  logic [2:0] fingers;
  logic [7:0] slot_b0, slot_b1;

  trd_pkg::trd_in_t byte_queue[$];
  trd_pkg::trd_out_t event_queue[$];
  int queued = 0;
  int accepted = 0;
  int mismatches = 0;
  logic in_took = 1'b0;
  logic no_gaps = 1'b0;

  function automatic logic [15:0] scale_coord(logic [11:0] v, logic [15:0] smax,
                                               logic [11:0] ext);
    int unsigned vv, ss, ee, r;
    vv = v;
    ss = smax;
    ee = ext;
    if (ee == 0) return 16'd0;
    r = (vv * ss) / ee;
    if (r > ss) r = ss;
    return r[15:0];
  endfunction

  task automatic predict_byte(input trd_pkg::trd_in_t it);
    trd_pkg::trd_out_t ev;
    logic hit;
    logic [15:0] sx, sy, t;
    int rel;
    ev = '0;
    hit = 1'b0;
    if (it.packet_start) begin
      byte_idx = '0;
      pkt_kind = it.data_byte;
      fingers = '0;
      if (it.data_byte == trd_pkg::TYPE_CALIB) begin
        hit = 1'b1;
        ev.event_kind = trd_pkg::EV_CALIB;
      end else if (it.data_byte == trd_pkg::TYPE_HELLO) begin
        hit = 1'b1;
        ev.event_kind = trd_pkg::EV_HELLO;
      end
    end else if (byte_idx < PKT_LEN - 1) begin
      byte_idx = byte_idx + 5'd1;
      if (pkt_kind == trd_pkg::TYPE_NOISE) begin
        if (byte_idx == 1) begin
          hit = 1'b1;
          ev.event_kind = trd_pkg::EV_NOISE;
          ev.noisy = (it.data_byte == trd_pkg::VAL_NOISY);
        end
      end else if (pkt_kind == trd_pkg::TYPE_REPORT) begin
        if (byte_idx == 1) begin
          fingers = it.data_byte[2:0] & trd_pkg::COUNT_MASK;
          if (fingers == 0) begin
            hit = 1'b1;
            ev.event_kind = trd_pkg::EV_NOFINGER;
          end
        end else begin
          if (byte_idx >= trd_pkg::SLOT_BASE &&
              byte_idx < trd_pkg::SLOT_BASE + 3 * NUM_SLOTS) begin
            rel = byte_idx - trd_pkg::SLOT_BASE;
            case (rel % 3)
              0: slot_b0 = it.data_byte;
              1: slot_b1 = it.data_byte;
              default: begin
                if (fingers != 0) begin
                  hit = 1'b1;
                  ev.slot_number = 3'(rel / 3);
                  if (slot_b0 == 0 && slot_b1 == 0 && it.data_byte == 0) begin
                    ev.event_kind = trd_pkg::EV_EMPTY;
                  end else begin
                    ev.event_kind = trd_pkg::EV_POINT;
                    sx = scale_coord({slot_b0[3:0], it.data_byte}, scr_x, pan_w);
                    sy = scale_coord({slot_b0[7:4], slot_b1}, scr_y, pan_h);
                    if (flip_x) sx = scr_x - sx;
                    if (flip_y) sy = scr_y - sy;
                    if (swap_xy) begin
                      t = sx;
                      sx = sy;
                      sy = t;
                    end
                    ev.pos_x = sx;
                    ev.pos_y = sy;
                  end
                end
              end
            endcase
          end
          if (!hit && byte_idx == PKT_LEN - 1) begin
            hit = 1'b1;
            ev.event_kind = trd_pkg::EV_FRAMEEND;
          end
        end
      end
    end
    if (hit) event_queue.push_back(ev);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        if (byte_queue.size() > 0 && (no_gaps || $urandom_range(99) >= 25)) begin
          in_data <= byte_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= no_gaps || ($urandom_range(99) >= 25);
    end
  end

  // monitor
  always @(posedge clk) begin
    trd_pkg::trd_out_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (event_queue.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected event, expected none,", $time,
                   " actual kind %0d slot %0d x %0d y %0d noisy %0d",
                   out_data.event_kind, out_data.slot_number, out_data.pos_x,
                   out_data.pos_y, out_data.noisy);
        end else begin
          want = event_queue.pop_front();
          if (out_data.event_kind !== want.event_kind ||
              out_data.slot_number !== want.slot_number ||
              out_data.pos_x !== want.pos_x || out_data.pos_y !== want.pos_y ||
              out_data.noisy !== want.noisy) begin
            mismatches++;
            $display("%0t: event mismatch, expected kind %0d slot %0d x %0d y %0d noisy %0d,",
                     $time, want.event_kind, want.slot_number, want.pos_x, want.pos_y,
                     want.noisy, " actual kind %0d slot %0d x %0d y %0d noisy %0d",
                     out_data.event_kind, out_data.slot_number, out_data.pos_x,
                     out_data.pos_y, out_data.noisy);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_byte(in_data);
        accepted <= accepted + 1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic start);
    trd_pkg::trd_in_t it;
    it.data_byte = b;
    it.packet_start = start;
    byte_queue.push_back(it);
    queued++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [trd_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      trd_pkg::CFG_DISP_MAX_X:   scr_x = val;
      trd_pkg::CFG_DISP_MAX_Y:   scr_y = val;
      trd_pkg::CFG_PANEL_WIDTH:  pan_w = val[11:0];
      trd_pkg::CFG_PANEL_HEIGHT: pan_h = val[11:0];
      trd_pkg::CFG_MIRROR_X:     flip_x = val[0];
      trd_pkg::CFG_MIRROR_Y:     flip_y = val[0];
      trd_pkg::CFG_SWAP_AXES:    swap_xy = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setup(input logic [15:0] sx, input logic [15:0] sy,
                            input logic [11:0] pw, input logic [11:0] ph,
                            input logic mx, input logic my, input logic sw);
    write_reg(trd_pkg::CFG_DISP_MAX_X, sx);
    write_reg(trd_pkg::CFG_DISP_MAX_Y, sy);
    write_reg(trd_pkg::CFG_PANEL_WIDTH, {4'd0, pw});
    write_reg(trd_pkg::CFG_PANEL_HEIGHT, {4'd0, ph});
    write_reg(trd_pkg::CFG_MIRROR_X, {15'd0, mx});
    write_reg(trd_pkg::CFG_MIRROR_Y, {15'd0, my});
    write_reg(trd_pkg::CFG_SWAP_AXES, {15'd0, sw});
  endtask

  // well-formed report with random content; a few are cut short or overlong
  task automatic add_report();
    int len, r, k;
    logic [7:0] cnt;
    logic [7:0] sb[3];
    len = PKT_LEN;
    r = $urandom_range(99);
    if (r < 8) len = $urandom_range(2, PKT_LEN - 1);
    else if (r < 16) len = $urandom_range(PKT_LEN + 1, PKT_LEN + 5);
    cnt = 8'($urandom_range(255));
    if ($urandom_range(4) == 0) cnt[2:0] = 3'd0;
    push_byte(trd_pkg::TYPE_REPORT, 1'b1);
    for (int p = 1; p < len; p++) begin
      if (p == 1) begin
        push_byte(cnt, 1'b0);
      end else if (p >= trd_pkg::SLOT_BASE && p < trd_pkg::SLOT_BASE + 3 * NUM_SLOTS) begin
        k = (p - trd_pkg::SLOT_BASE) % 3;
        if (k == 0) begin
          r = $urandom_range(9);
          for (int j = 0; j < 3; j++)
            sb[j] = (r < 2) ? 8'h00 : (r == 2) ? 8'hFF : 8'($urandom_range(255));
        end
        push_byte(sb[k], 1'b0);
      end else begin
        push_byte(8'($urandom_range(255)), 1'b0);
      end
    end
  endtask

  task automatic random_traffic(input int n);
    int stop, r;
    stop = queued + n;
    while (queued < stop) begin
      r = $urandom_range(99);
      if (r < 60) begin
        add_report();
      end else if (r < 70) begin
        push_byte(trd_pkg::TYPE_NOISE, 1'b1);
        push_byte(($urandom_range(1) == 0) ? trd_pkg::VAL_NOISY : 8'($urandom_range(255)),
                  1'b0);
      end else if (r < 75) begin
        push_byte(trd_pkg::TYPE_CALIB, 1'b1);
      end else if (r < 80) begin
        push_byte(trd_pkg::TYPE_HELLO, 1'b1);
      end else begin
        push_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
      end
    end
  endtask

  task automatic settle();
    while (accepted != queued || event_queue.size() != 0) @(posedge clk);
    repeat (30) @(negedge clk);
  endtask

  initial begin
    scr_x = trd_pkg::DISP_MAX_X_RST;
    scr_y = trd_pkg::DISP_MAX_Y_RST;
    pan_w = trd_pkg::PANEL_EXT_RST;
    pan_h = trd_pkg::PANEL_EXT_RST;
    flip_x = 1'b0;
    flip_y = 1'b0;
    swap_xy = 1'b0;
    byte_idx = '0;
    pkt_kind = '0;
    fingers = '0;
    slot_b0 = '0;
    slot_b1 = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // stray bytes before any start, status packets, one report with edge slots
    push_byte(trd_pkg::TYPE_REPORT, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(trd_pkg::TYPE_CALIB, 1'b1);
    push_byte(trd_pkg::TYPE_HELLO, 1'b1);
    push_byte(trd_pkg::TYPE_NOISE, 1'b1);
    push_byte(trd_pkg::VAL_NOISY, 1'b0);
    push_byte(trd_pkg::TYPE_NOISE, 1'b1);
    push_byte(trd_pkg::TYPE_NOISE, 1'b0);
    push_byte(trd_pkg::TYPE_REPORT, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h0F, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'hF0, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hA5, 1'b0); push_byte(8'h5A, 1'b0); push_byte(8'hC3, 1'b0);
    for (int p = trd_pkg::SLOT_BASE + 3 * NUM_SLOTS; p < PKT_LEN; p++)
      push_byte(8'h80, 1'b0);
    push_byte(8'h77, 1'b0);
    random_traffic(45);
    settle();

    load_setup(16'd65535, 16'd1, 12'd1, 12'd4095, 1'b1, 1'b1, 1'b1);
    no_gaps = 1'b1;
    random_traffic(45);
    settle();
    no_gaps = 1'b0;

    load_setup(16'd1, 16'd65535, 12'd0, 12'd1, 1'b0, 1'b1, 1'b0);
    random_traffic(45);
    settle();

    repeat (5) begin
      load_setup(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                 ($urandom_range(7) == 0) ? 12'd0 : 12'($urandom_range(4095)),
                 ($urandom_range(7) == 0) ? 12'd0 : 12'($urandom_range(4095)),
                 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      random_traffic(40);
      settle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/trd_pkg.sv
rtl/trd_scaler.sv
rtl/touch_report_decoder.sv
tb/tb.sv
